FILE: src/tusb_pkg.sv
// ----------------------------------------------------------------------------
// tusb_pkg: shared types and codes of the texture unit staleness binder
// Request and result words, controller/datapath command and status groups,
// operation, status and unit-select codes.
// ----------------------------------------------------------------------------
`default_nettype none

package tusb_pkg;

   localparam int NUM_UNITS_DEF = 16;
   localparam int ID_BITS_DEF   = 16;
   localparam int STALE_W       = 32;

   // request types
   localparam logic [2:0] OP_ACQUIRE = 3'd0;
   localparam logic [2:0] OP_BIND    = 3'd1;
   localparam logic [2:0] OP_RELEASE = 3'd2;
   localparam logic [2:0] OP_TICK    = 3'd3;
   localparam logic [2:0] OP_CLEAR   = 3'd4;

   // result status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_ROOM = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;
   localparam logic [1:0] ST_RANGE   = 2'd3;

   // unit select for commit and result
   localparam logic [1:0] SEL_NONE = 2'd0;
   localparam logic [1:0] SEL_HIT  = 2'd1;
   localparam logic [1:0] SEL_PICK = 2'd2;
   localparam logic [1:0] SEL_REQ  = 2'd3;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [15:0] texture_id;
      logic [3:0]  bind_unit;
      logic        texture_known;
   } tusb_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [3:0] unit;
      logic       hit;
   } tusb_rsp_type;

   typedef struct packed {
      logic       capture;
      logic       rd_en;
      logic       track;
      logic       unbind;
      logic       tick;
      logic       clear_all;
      logic       wr_bind;
      logic       wr_zero;
      logic       respond;
      logic [1:0] unit_sel;
      logic [1:0] status;
      logic       hit;
   } tusb_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       known;
      logic       range_bad;
      logic       scan_last;
      logic       hit_found;
      logic       best_zero;
   } tusb_sts_type;

endpackage

`default_nettype wire

FILE: src/texture_unit_staleness_binder_top.sv
// ----------------------------------------------------------------------------
// texture_unit_staleness_binder_top: texture id to unit binder
// Maps texture ids onto units 1..NUM_UNITS-1 with per-unit staleness
// counters; acquire, explicit bind, release, frame tick and clear all.
// ----------------------------------------------------------------------------
//
//   channel   ports                      handshake
//   -------   ------------------------   ---------------------------------
//   request   start, busy, req_word      taken when start=1 and busy=0
//   result    rsp_strobe, rsp_word       one word per request, one cycle
//
// Scan: acquire, bind, release and frame tick scan units 1..NUM_UNITS-1,
// one unit per cycle through the single read port of the owner and
// staleness memories, so busy stays high through decode, scan, drain
// and commit. Bind and release requests rejected in decode, clear all
// and undefined types answer there. The result word strobes in the
// first cycle with busy low; a new word can be taken in that same cycle.
// Reset clears the bound bits and the staleness written bits; an unwritten
// staleness entry reads as one (unit 0 is never scanned).
// The receiver cannot stall: every result is strobed exactly once.
//
`default_nettype none

module texture_unit_staleness_binder_top #(
   parameter int NUM_UNITS = tusb_pkg::NUM_UNITS_DEF,
   parameter int ID_BITS   = tusb_pkg::ID_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire tusb_pkg::tusb_req_type req_word,
   output logic                        rsp_strobe,
   output tusb_pkg::tusb_rsp_type      rsp_word
);

   // command and status between the sequencer and the tables
   tusb_pkg::tusb_cmd_type cmd;
   tusb_pkg::tusb_sts_type sts;

   // sequence decode, scan, drain and commit
   tusb_controller u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   // hold the tables, run the scan and register the result word
   tusb_datapath #(
      .NUM_UNITS (NUM_UNITS),
      .ID_BITS   (ID_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_word   (req_word),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

endmodule

`default_nettype wire

FILE: src/tusb_datapath.sv
// ----------------------------------------------------------------------------
// tusb_datapath: unit tables, scan pipeline and result register
// Owner and staleness memories, bound and written bits, the scan address,
// the hit/stalest trackers and the registered result word.
// ----------------------------------------------------------------------------
`default_nettype none

module tusb_datapath #(
   parameter int NUM_UNITS = tusb_pkg::NUM_UNITS_DEF,
   parameter int ID_BITS   = tusb_pkg::ID_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tusb_pkg::tusb_req_type req_word,
   input  wire tusb_pkg::tusb_cmd_type cmd,
   output tusb_pkg::tusb_sts_type     sts,
   output logic                       rsp_strobe,
   output tusb_pkg::tusb_rsp_type     rsp_word
);

   localparam int UNIT_W = (NUM_UNITS > 1) ? $clog2(NUM_UNITS) : 1;
   localparam int SW     = tusb_pkg::STALE_W;

   logic [ID_BITS-1:0] owner_mem [NUM_UNITS];
   logic [SW-1:0]      stale_mem [NUM_UNITS];

   tusb_pkg::tusb_req_type req_ff;
   logic [ID_BITS-1:0]     req_id;
   logic [UNIT_W-1:0]      req_unit;

   logic [UNIT_W-1:0]    addr_ff, addr_in;
   logic [UNIT_W-1:0]    addr_d_ff;
   logic                 rd_vld_ff;
   logic [ID_BITS-1:0]   rd_owner_ff;
   logic [SW-1:0]        rd_stale_ff;

   logic [NUM_UNITS-1:0] bound_ff, bound_in;
   logic [NUM_UNITS-1:0] written_ff, written_in;

   logic                 hit_found_ff, hit_found_in;
   logic [UNIT_W-1:0]    hit_unit_ff, hit_unit_in;
   logic [SW-1:0]        best_ff, best_in;
   logic [UNIT_W-1:0]    pick_ff, pick_in;

   logic                 rsp_strobe_ff;
   tusb_pkg::tusb_rsp_type rsp_word_ff;

   logic [SW-1:0]        eff_stale;
   logic [SW-1:0]        stale_inc;
   logic                 match;
   logic [UNIT_W-1:0]    sel_unit;
   logic                 st_wr_en;
   logic [UNIT_W-1:0]    st_wr_addr;
   logic [SW-1:0]        st_wr_data;

   assign req_id   = ID_BITS'(req_ff.texture_id);
   assign req_unit = UNIT_W'(req_ff.bind_unit);

   // unwritten staleness reads as its reset value; the scan never visits unit 0
   assign eff_stale = written_ff[addr_d_ff] ? rd_stale_ff : SW'(1);
   assign stale_inc = (eff_stale == {SW{1'b1}}) ? eff_stale : eff_stale + SW'(1);
   assign match     = rd_vld_ff && bound_ff[addr_d_ff] && (rd_owner_ff == req_id);

   always_comb begin
      case (cmd.unit_sel)
         tusb_pkg::SEL_HIT:  sel_unit = hit_unit_ff;
         tusb_pkg::SEL_PICK: sel_unit = pick_ff;
         tusb_pkg::SEL_REQ:  sel_unit = req_unit;
         default:            sel_unit = '0;
      endcase
   end

   assign st_wr_en   = (rd_vld_ff && cmd.tick) || cmd.wr_zero;
   assign st_wr_addr = cmd.wr_zero ? sel_unit : addr_d_ff;
   assign st_wr_data = cmd.wr_zero ? '0 : stale_inc;

   always_comb begin
      addr_in = addr_ff;
      if (cmd.capture) begin
         addr_in = UNIT_W'(1);
      end else if (cmd.rd_en) begin
         addr_in = addr_ff + UNIT_W'(1);
      end
   end

   always_comb begin
      hit_found_in = hit_found_ff;
      hit_unit_in  = hit_unit_ff;
      best_in      = best_ff;
      pick_in      = pick_ff;
      if (cmd.capture) begin
         hit_found_in = 1'b0;
         hit_unit_in  = '0;
         best_in      = '0;
         pick_in      = '0;
      end else if (rd_vld_ff && cmd.track) begin
         if (match && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_unit_in  = addr_d_ff;
         end
         // strict compare keeps the lowest index on a tie
         if (eff_stale > best_ff) begin
            best_in = eff_stale;
            pick_in = addr_d_ff;
         end
      end
   end

   always_comb begin
      bound_in = bound_ff;
      if (cmd.clear_all) begin
         bound_in = '0;
      end
      if (cmd.unbind && match) begin
         bound_in[addr_d_ff] = 1'b0;
      end
      if (cmd.wr_bind) begin
         bound_in[sel_unit] = 1'b1;
      end
   end

   always_comb begin
      written_in = written_ff;
      if (st_wr_en) begin
         written_in[st_wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         bound_ff      <= '0;
         written_ff    <= '0;
         hit_found_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         addr_ff       <= addr_in;
         rd_vld_ff     <= cmd.rd_en;
         bound_ff      <= bound_in;
         written_ff    <= written_in;
         hit_found_ff  <= hit_found_in;
         rsp_strobe_ff <= cmd.respond;
      end
   end

   always_ff @(posedge clock) begin
      hit_unit_ff <= hit_unit_in;
      best_ff     <= best_in;
      pick_ff     <= pick_in;
      if (cmd.capture) begin
         req_ff <= req_word;
      end
      if (cmd.rd_en) begin
         addr_d_ff <= addr_ff;
      end
      if (cmd.respond) begin
         rsp_word_ff.status <= cmd.status;
         rsp_word_ff.unit   <= 4'(sel_unit);
         rsp_word_ff.hit    <= cmd.hit;
      end
   end

   // owner and staleness memories: one write and one registered read a cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_bind) begin
         owner_mem[sel_unit] <= req_id;
      end
      if (cmd.rd_en) begin
         rd_owner_ff <= owner_mem[addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (st_wr_en) begin
         stale_mem[st_wr_addr] <= st_wr_data;
      end
      if (cmd.rd_en) begin
         rd_stale_ff <= stale_mem[addr_ff];
      end
   end

   assign sts.op        = req_ff.req_type;
   assign sts.known     = req_ff.texture_known;
   assign sts.range_bad = (req_ff.bind_unit == 4'd0) ||
                          (32'(req_ff.bind_unit) >= 32'(NUM_UNITS));
   assign sts.scan_last = (addr_ff == UNIT_W'(NUM_UNITS - 1));
   assign sts.hit_found = hit_found_ff;
   assign sts.best_zero = (best_ff == '0);

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

`ifndef SYNTHESIS
   a_unit0_free: assert property (@(posedge clock) disable iff (reset)
      !bound_ff[0])
      else $error("unit 0 became bound");
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> rsp_strobe_ff)
      else $error("result strobe missing after respond");
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && rsp_word_ff.hit) |-> (rsp_word_ff.status == tusb_pkg::ST_OK))
      else $error("hit reported with failing status");
`endif

endmodule

`default_nettype wire

FILE: src/tusb_controller.sv
// ----------------------------------------------------------------------------
// tusb_controller: request sequencer
// Decodes the captured request, runs the unit scan and issues the commit
// and result commands to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module tusb_controller (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire tusb_pkg::tusb_sts_type sts,
   output tusb_pkg::tusb_cmd_type      cmd,
   output logic                        busy
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_COMMIT = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.op)
               tusb_pkg::OP_ACQUIRE, tusb_pkg::OP_TICK: begin
                  state_in = S_SCAN;
               end
               tusb_pkg::OP_BIND: begin
                  if (sts.range_bad) begin
                     cmd.respond = 1'b1;
                     cmd.status  = tusb_pkg::ST_RANGE;
                     state_in    = S_IDLE;
                  end else if (!sts.known) begin
                     cmd.respond = 1'b1;
                     cmd.status  = tusb_pkg::ST_UNKNOWN;
                     state_in    = S_IDLE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               tusb_pkg::OP_RELEASE: begin
                  if (!sts.known) begin
                     cmd.respond = 1'b1;
                     cmd.status  = tusb_pkg::ST_UNKNOWN;
                     state_in    = S_IDLE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end
               tusb_pkg::OP_CLEAR: begin
                  cmd.clear_all = 1'b1;
                  cmd.respond   = 1'b1;
                  state_in      = S_IDLE;
               end
               default: begin
                  cmd.respond = 1'b1;
                  state_in    = S_IDLE;
               end
            endcase
         end
         S_SCAN: begin
            cmd.rd_en = 1'b1;
            if (sts.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
            case (sts.op)
               tusb_pkg::OP_ACQUIRE: begin
                  if (sts.hit_found) begin
                     cmd.wr_zero  = 1'b1;
                     cmd.unit_sel = tusb_pkg::SEL_HIT;
                     cmd.hit      = 1'b1;
                  end else if (sts.best_zero) begin
                     cmd.status = tusb_pkg::ST_NO_ROOM;
                  end else if (!sts.known) begin
                     cmd.status = tusb_pkg::ST_UNKNOWN;
                  end else begin
                     cmd.wr_bind  = 1'b1;
                     cmd.wr_zero  = 1'b1;
                     cmd.unit_sel = tusb_pkg::SEL_PICK;
                  end
               end
               tusb_pkg::OP_BIND: begin
                  cmd.wr_bind  = 1'b1;
                  cmd.unit_sel = tusb_pkg::SEL_REQ;
               end
               default: begin
                  cmd.unit_sel = tusb_pkg::SEL_NONE;
               end
            endcase
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // hold the scan mode while reads are issued and the last one drains
      if ((state_ff == S_SCAN) || (state_ff == S_DRAIN)) begin
         cmd.track  = (sts.op == tusb_pkg::OP_ACQUIRE);
         cmd.unbind = (sts.op == tusb_pkg::OP_BIND) || (sts.op == tusb_pkg::OP_RELEASE);
         cmd.tick   = (sts.op == tusb_pkg::OP_TICK);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

`ifndef SYNTHESIS
   a_start_decode: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_DECODE))
      else $error("accepted word did not reach decode");
   a_respond_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.respond |=> !busy)
      else $error("controller still busy after result");
   a_scan_hold: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_SCAN) && !sts.scan_last) |=> (state_ff == S_SCAN))
      else $error("scan left early");
`endif

endmodule

`default_nettype wire
